FILE: rtl/core/fqs_pkg.sv
package fqs_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned StatW    = 2;
  localparam int unsigned WordW    = 32;
  localparam int unsigned PosW     = 4;

  typedef enum logic [ReqW-1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_SRCH = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RS_OK,
    RS_FULL,
    RS_EMPTY,
    RS_NOTFOUND,
    RS_DEQ,
    RS_HIT
  } res_sel_e;

  typedef struct packed {
    logic     push;
    logic     pop;
    logic     scan_init;
    logic     scan_next;
    logic     res_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic hit;
    logic last;
  } stat_t;

endpackage

FILE: rtl/core/fqs_ctrl.sv
module fqs_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fqs_pkg::ReqW-1:0]     req_type_i,
  input  fqs_pkg::stat_t               stat_i,
  output fqs_pkg::cmd_t                cmd_o,
  output logic                         busy_o
);
  import fqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DEQ  = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = RS_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_e'(req_type_i))
            REQ_ENQ: begin
              cmd_o.res_load = 1'b1;
              if (stat_i.full) begin
                cmd_o.res_sel = RS_FULL;
              end else begin
                cmd_o.push    = 1'b1;
                cmd_o.res_sel = RS_OK;
              end
            end
            REQ_DEQ: begin
              if (stat_i.empty) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = RS_EMPTY;
              end else begin
                state_d = S_DEQ;
              end
            end
            REQ_SRCH: begin
              if (stat_i.empty) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = RS_EMPTY;
              end else begin
                cmd_o.scan_init = 1'b1;
                state_d         = S_SCAN;
              end
            end
            default: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RS_OK;
            end
          endcase
        end
      end
      S_DEQ: begin
        cmd_o.pop      = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RS_DEQ;
        state_d        = S_IDLE;
      end
      S_SCAN: begin
        priority if (stat_i.hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RS_HIT;
          state_d        = S_IDLE;
        end else if (stat_i.last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RS_NOTFOUND;
          state_d        = S_IDLE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: rtl/core/fqs_dp.sv
module fqs_dp #(
  parameter int unsigned DEPTH = fqs_pkg::DefDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [fqs_pkg::WordW-1:0]  value_i,
  input  fqs_pkg::cmd_t                     cmd_i,
  output fqs_pkg::stat_t                    stat_o,
  output logic                              done_o,
  output logic [fqs_pkg::StatW-1:0]         status_o,
  output logic signed [fqs_pkg::WordW-1:0]  data_out_o,
  output logic [fqs_pkg::PosW-1:0]          position_o
);
  import fqs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);
  localparam logic [OW-1:0] FullOcc  = OW'(DEPTH);

  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rdata_q;
  logic [AW-1:0]    rd_addr;

  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [OW-1:0] occ_q, occ_d;
  logic [AW-1:0] scan_ptr_q, scan_ptr_d;
  logic [AW-1:0] scan_idx_q, scan_idx_d;
  logic [WordW-1:0] key_q;

  logic                    done_q;
  logic [StatW-1:0]        status_q, status_d;
  logic signed [WordW-1:0] data_q, data_d;
  logic [PosW-1:0]         pos_q, pos_d;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
    return (p == LastAddr) ? '0 : p + 1'b1;
  endfunction

  assign rd_addr = cmd_i.scan_next ? scan_ptr_q : head_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[tail_q] <= value_i;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    scan_ptr_d = scan_ptr_q;
    scan_idx_d = scan_idx_q;
    if (cmd_i.push) begin
      tail_d = wrap_next(tail_q);
      occ_d  = occ_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d = wrap_next(head_q);
      occ_d  = occ_q - 1'b1;
    end
    if (cmd_i.scan_init) begin
      scan_ptr_d = wrap_next(head_q);
      scan_idx_d = '0;
    end
    if (cmd_i.scan_next) begin
      scan_ptr_d = wrap_next(scan_ptr_q);
      scan_idx_d = scan_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      occ_q      <= '0;
      scan_ptr_q <= '0;
      scan_idx_q <= '0;
      done_q     <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      occ_q      <= occ_d;
      scan_ptr_q <= scan_ptr_d;
      scan_idx_q <= scan_idx_d;
      done_q     <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      key_q <= value_i;
    end
    if (cmd_i.res_load) begin
      status_q <= status_d;
      data_q   <= data_d;
      pos_q    <= pos_d;
    end
  end

  always_comb begin
    status_d = ST_OK;
    data_d   = '0;
    pos_d    = '0;
    unique case (cmd_i.res_sel)
      RS_OK:       status_d = ST_OK;
      RS_FULL:     status_d = ST_FULL;
      RS_EMPTY:    status_d = ST_EMPTY;
      RS_NOTFOUND: status_d = ST_NOTFOUND;
      RS_DEQ:      data_d   = rdata_q;
      RS_HIT:      pos_d    = PosW'(scan_idx_q);
      default:     status_d = ST_OK;
    endcase
  end

  assign stat_o.empty = (occ_q == '0);
  assign stat_o.full  = (occ_q == FullOcc);
  assign stat_o.hit   = (rdata_q == key_q);
  assign stat_o.last  = ({1'b0, scan_idx_q} + 1'b1) == (AW + 1)'(occ_q);

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign data_out_o = data_q;
  assign position_o = pos_q;

endmodule

FILE: rtl/core/fifo_queue_with_search.sv
// A queue of DEPTH signed 32-bit words with enqueue, dequeue and search requests. A request
// is taken when start_i is high and busy_o is low, and each request returns exactly one word
// on the result ports, shown for a single cycle with done_o high; the receiver cannot stall it.
// Enqueue and rejected requests finish without leaving the idle state and leave busy_o low,
// dequeue passes through S_DEQ for the registered memory read, and a search compares entries
// from the head in S_SCAN until a hit or the last one, since the single memory read port feeds one compare a cycle.
module fifo_queue_with_search #(
  parameter int unsigned DEPTH = fqs_pkg::DefDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [fqs_pkg::ReqW-1:0]          req_type_i,
  input  logic signed [fqs_pkg::WordW-1:0]  value_i,
  output logic                              done_o,
  output logic [fqs_pkg::StatW-1:0]         status_o,
  output logic signed [fqs_pkg::WordW-1:0]  data_out_o,
  output logic [fqs_pkg::PosW-1:0]          position_o
);
  import fqs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  fqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .done_o     (done_o),
    .status_o   (status_o),
    .data_out_o (data_out_o),
    .position_o (position_o)
  );

endmodule
